// ===== hw/rtl/asgc_pkg.sv =====
// Shared widths, register indexes and reset values for the shift gain control block.
package asgc_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned SAMPLE_W   = 24;
	localparam int unsigned THRESH_W   = 31;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned HR_W       = 5;
	localparam int unsigned VOTES_W    = 8;
	localparam int unsigned SHIFT_W    = 5;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHIFT_THRESHOLD  = 3'd0,
		CFG_PERIOD_SAMPLES   = 3'd1,
		CFG_DESIRED_HEADROOM = 3'd2,
		CFG_HYSTERESIS_BITS  = 3'd3,
		CFG_RAISE_PERIODS    = 3'd4,
		CFG_MAX_SHIFT        = 3'd5
	} cfg_index_t;

	localparam logic [THRESH_W-1:0] THRESHOLD_RST = 31'd0;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd320;
	localparam logic [HR_W-1:0]     DESIRED_RST   = 5'd1;
	localparam logic [HR_W-1:0]     HYST_RST      = 5'd1;
	localparam logic [VOTES_W-1:0]  RAISE_RST     = 8'd10;
	localparam logic [SHIFT_W-1:0]  MAX_SHIFT_RST = 5'd12;

	localparam logic [SHIFT_W-1:0]  SHIFT_DEFAULT = 5'd0;
	localparam logic [CNT_W-1:0]    HEADROOM_TOP  = 6'd63;
	// magnitude never exceeds 2^23, so bits 30..24 are always unused
	localparam logic [CNT_W-1:0]    HEADROOM_FLOOR = 6'd7;

endpackage

// ===== hw/rtl/asgc_ifs.sv =====
// Valid/ready channel interfaces for the sample input and the gained result output.
interface asgc_in_if;
	logic                          valid;
	logic                          ready;
	logic [asgc_pkg::WORD_W-1:0]   raw_word;

	modport source (output valid, output raw_word, input ready);
	modport sink   (input valid, input raw_word, output ready);
endinterface

interface asgc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [asgc_pkg::WORD_W-1:0] gained_sample;
	logic [asgc_pkg::SHIFT_W-1:0]       gain_shift;

	modport source (output valid, output gained_sample, output gain_shift, input ready);
	modport sink   (input valid, input gained_sample, input gain_shift, output ready);
endinterface

// ===== hw/rtl/audio_shift_gain_control.sv =====
// Shift-based automatic gain control: one audio word in, one gained sample out.
//
// Usage:
//   sample_ch carries one 32-bit audio word per beat; bits 31..8 hold a signed
//   24-bit sample. result_ch returns one beat per input beat: the sign-extended
//   sample, shifted left by the gain in force if its magnitude is above the
//   threshold, and the gain shift after this sample's update.
//   Registers are written through cfg_we / cfg_index / cfg_data, by the user only
//   while the block is idle (the block does not enforce it). Unknown indexes are ignored.
// Timing:
//   Each beat passes the input register, then the result register; while
//   result_ch is held off, a beat can wait in either register.
//   Throughput is one sample per cycle while result_ch is ready; the gain state loop
//   (leading-zero count, minimum, period update) is combinational between its registers.
// Reset:
//   arst_n clears both stages, loads the register defaults, sets the gain to
//   its default, the headroom minimum to 63 and the period and vote counters
//   to zero.
// Stall:
//   While result_ch is held off the result register holds its beat; the input
//   register still takes one more beat if it is empty, then sample_ch.ready drops.
module audio_shift_gain_control (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [asgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asgc_pkg::CFG_DATA_W-1:0]    cfg_data,
	asgc_in_if.sink                            sample_ch,
	asgc_out_if.source                         result_ch
);

	// configuration
	logic [asgc_pkg::THRESH_W-1:0] threshold_q;
	logic [asgc_pkg::PERIOD_W-1:0] period_samples_q;
	logic [asgc_pkg::HR_W-1:0]     desired_q;
	logic [asgc_pkg::HR_W-1:0]     hyst_q;
	logic [asgc_pkg::VOTES_W-1:0]  raise_periods_q;
	logic [asgc_pkg::SHIFT_W-1:0]  max_shift_q;

	// gain state
	logic [asgc_pkg::SHIFT_W-1:0]  current_shift_q;
	logic [asgc_pkg::CNT_W-1:0]    headroom_min_q;
	logic [asgc_pkg::PERIOD_W-1:0] period_count_q;
	logic [asgc_pkg::VOTES_W-1:0]  raise_votes_q;

	// pipeline
	logic                               valid_s1;
	logic [asgc_pkg::WORD_W-1:0]        raw_word_s1;
	logic                               valid_s2;
	logic signed [asgc_pkg::WORD_W-1:0] gained_s2;
	logic [asgc_pkg::SHIFT_W-1:0]       shift_s2;

	logic                               adv;
	logic                               take_in;
	logic                               neg;
	logic [asgc_pkg::SAMPLE_W-1:0]      mag;
	logic [asgc_pkg::CNT_W-1:0]         unused;
	logic signed [asgc_pkg::WORD_W-1:0] sample;
	logic signed [asgc_pkg::WORD_W-1:0] gained;
	logic                               above;
	logic [asgc_pkg::CNT_W-1:0]         hm_min;
	logic [asgc_pkg::CNT_W-1:0]         hm_relax;
	logic [asgc_pkg::PERIOD_W-1:0]      pc_inc;
	logic                               period_end;
	logic [asgc_pkg::SHIFT_W-1:0]       cs_cap;
	logic [asgc_pkg::CNT_W-1:0]         diff;
	logic [asgc_pkg::CNT_W-1:0]         raise_lim;
	logic [asgc_pkg::VOTES_W:0]         votes;
	logic [asgc_pkg::SHIFT_W-1:0]       cs_next;
	logic [asgc_pkg::VOTES_W-1:0]       rv_next;
	logic [asgc_pkg::CNT_W-1:0]         hm_next;
	logic [asgc_pkg::PERIOD_W-1:0]      pc_next;

	// unused magnitude bits counted from bit 30 down; 31 for zero
	function automatic logic [asgc_pkg::CNT_W-1:0] lead_unused(
		input logic [asgc_pkg::SAMPLE_W-1:0] m
	);
		logic [asgc_pkg::CNT_W-1:0] cnt;
		cnt = 6'd31;
		for (int i = 0; i < asgc_pkg::SAMPLE_W; i++) begin
			if (m[i]) begin
				cnt = 6'(30 - i);
			end
		end
		return cnt;
	endfunction

	assign adv             = valid_s1 && (!valid_s2 || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || adv;
	assign take_in         = sample_ch.valid && sample_ch.ready;

	assign result_ch.valid         = valid_s2;
	assign result_ch.gained_sample = gained_s2;
	assign result_ch.gain_shift    = shift_s2;

	always_comb begin
		neg    = raw_word_s1[31];
		sample = {{8{raw_word_s1[31]}}, raw_word_s1[31:8]};
		mag    = neg ? (~raw_word_s1[31:8] + 24'd1) : raw_word_s1[31:8];
		unused = lead_unused(mag);
		above  = {7'd0, mag} > threshold_q;
		gained = above ? (sample <<< current_shift_q) : sample;

		hm_min     = (unused < headroom_min_q) ? unused : headroom_min_q;
		hm_relax   = (hm_min < asgc_pkg::HEADROOM_TOP) ? hm_min + 6'd1 : hm_min;
		pc_inc     = period_count_q + 16'd1;
		period_end = pc_inc >= period_samples_q;

		// cap at the period minimum, then a step down, a vote or a rise by one
		cs_cap    = ({1'b0, current_shift_q} > hm_min) ? hm_min[4:0] : current_shift_q;
		diff      = hm_min - {1'b0, cs_cap};
		raise_lim = {1'b0, desired_q} + {1'b0, hyst_q};
		votes     = {1'b0, raise_votes_q} + 9'd1;

		cs_next = current_shift_q;
		rv_next = raise_votes_q;
		hm_next = hm_min;
		pc_next = pc_inc;
		if (period_end) begin
			pc_next = '0;
			hm_next = hm_relax;
			cs_next = cs_cap;
			if (diff > raise_lim && cs_cap < max_shift_q) begin
				if (votes > {1'b0, raise_periods_q}) begin
					cs_next = cs_cap + 5'd1;
					rv_next = '0;
				end else begin
					rv_next = votes[7:0];
				end
			end else if (diff < {1'b0, desired_q} && cs_cap != '0) begin
				cs_next = cs_cap - 5'd1;
				rv_next = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q      <= asgc_pkg::THRESHOLD_RST;
			period_samples_q <= asgc_pkg::PERIOD_RST;
			desired_q        <= asgc_pkg::DESIRED_RST;
			hyst_q           <= asgc_pkg::HYST_RST;
			raise_periods_q  <= asgc_pkg::RAISE_RST;
			max_shift_q      <= asgc_pkg::MAX_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				asgc_pkg::CFG_SHIFT_THRESHOLD:  threshold_q      <= cfg_data;
				asgc_pkg::CFG_PERIOD_SAMPLES:   period_samples_q <= cfg_data[15:0];
				asgc_pkg::CFG_DESIRED_HEADROOM: desired_q        <= cfg_data[4:0];
				asgc_pkg::CFG_HYSTERESIS_BITS:  hyst_q           <= cfg_data[4:0];
				asgc_pkg::CFG_RAISE_PERIODS:    raise_periods_q  <= cfg_data[7:0];
				asgc_pkg::CFG_MAX_SHIFT:        max_shift_q      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_shift_q <= asgc_pkg::SHIFT_DEFAULT;
			headroom_min_q  <= asgc_pkg::HEADROOM_TOP;
			period_count_q  <= '0;
			raise_votes_q   <= '0;
		end else if (adv) begin
			current_shift_q <= cs_next;
			headroom_min_q  <= hm_next;
			period_count_q  <= pc_next;
			raise_votes_q   <= rv_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !adv);
			valid_s2 <= adv || (valid_s2 && !result_ch.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			raw_word_s1 <= sample_ch.raw_word;
		end
		if (adv) begin
			gained_s2 <= gained;
			shift_s2  <= cs_next;
		end
	end

	// a beat only moves into the result register when that slot is free
	a_adv_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (!valid_s2 || result_ch.ready))
		else $error("input stage advanced into an occupied result register");

	// gain state changes only with a beat moving through
	a_shift_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(current_shift_q) && $stable(period_count_q))
		else $error("gain state changed without a beat");

	// no sample has fewer than seven unused bits
	a_headroom_floor: assert property (@(posedge clk) disable iff (!arst_n)
		headroom_min_q >= asgc_pkg::HEADROOM_FLOOR)
		else $error("headroom minimum below the magnitude floor");

	// empty input stage must always accept
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> sample_ch.ready)
		else $error("input stage empty but not ready");

	// result register shows the gain held in the state register after its update
	a_shift_matches: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> shift_s2 == current_shift_q)
		else $error("reported gain shift differs from the gain state");

endmodule
